@@ rtl/laser_charge_fire_pulse_sequencer_defines.svh @@
//------------------------------------------------------------------------------
// Laser charge/fire sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer RTL.
//------------------------------------------------------------------------------
`ifndef LASER_CHARGE_FIRE_PULSE_SEQUENCER_DEFINES_SVH
`define LASER_CHARGE_FIRE_PULSE_SEQUENCER_DEFINES_SVH

// Property checked at every edge outside reset.
`define LCFPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define LCFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lcfps_pkg.sv @@
//------------------------------------------------------------------------------
// Laser charge/fire sequencer package
// Configuration register types, indexes and reset values.
//------------------------------------------------------------------------------
`default_nettype none

package lcfps_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_W-1:0]     cfg_word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARGE_START = 3'd0,
        REG_CHARGE_STOP  = 3'd1,
        REG_PULSE_ON     = 3'd2,
        REG_PULSE_OFF    = 3'd3,
        REG_MIN_PERIOD   = 3'd4,
        REG_CYCLE_PERIOD = 3'd5
    } cfg_index_e;

    typedef struct packed {
        cfg_word_t charge_start_tick;
        cfg_word_t charge_stop_tick;
        cfg_word_t pulse_on_tick;
        cfg_word_t pulse_off_tick;
        cfg_word_t min_period;
        cfg_word_t cycle_period;
    } cfg_t;

    localparam cfg_word_t RST_CHARGE_START = 16'd0;
    localparam cfg_word_t RST_CHARGE_STOP  = 16'd10;
    localparam cfg_word_t RST_PULSE_ON     = 16'd12;
    localparam cfg_word_t RST_PULSE_OFF    = 16'd13;
    localparam cfg_word_t RST_MIN_PERIOD   = 16'd20;
    localparam cfg_word_t RST_CYCLE_PERIOD = 16'd100;

endpackage

`default_nettype wire

@@ rtl/lcfps_in_if.sv @@
//------------------------------------------------------------------------------
// Sequencer tick channel
// Valid/ready channel carrying one timer tick word with command levels.
//------------------------------------------------------------------------------
`default_nettype none

interface lcfps_in_if;

    logic valid;
    logic ready;
    logic fire_command;
    logic charge_command;
    logic fire_request;

    modport source (
        output valid,
        output fire_command,
        output charge_command,
        output fire_request,
        input  ready
    );

    modport sink (
        input  valid,
        input  fire_command,
        input  charge_command,
        input  fire_request,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/lcfps_out_if.sv @@
//------------------------------------------------------------------------------
// Sequencer result channel
// Valid/ready channel carrying one output level word per tick.
//------------------------------------------------------------------------------
`default_nettype none

interface lcfps_out_if;

    logic valid;
    logic ready;
    logic inhibit_out;
    logic fire_out;
    logic cycle_running;
    logic request_taken;

    modport source (
        output valid,
        output inhibit_out,
        output fire_out,
        output cycle_running,
        output request_taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  inhibit_out,
        input  fire_out,
        input  cycle_running,
        input  request_taken,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/lcfps_cfg_regs.sv @@
//------------------------------------------------------------------------------
// Sequencer configuration registers
// Six 16-bit tick/period registers; writes to unused indexes are dropped.
//------------------------------------------------------------------------------
`default_nettype none

module lcfps_cfg_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire lcfps_pkg::cfg_idx_t  wr_index,
    input  wire lcfps_pkg::cfg_word_t wr_data,
    output lcfps_pkg::cfg_t          cfg
);
    import lcfps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_e'(wr_index))
                REG_CHARGE_START: cfg_next.charge_start_tick = wr_data;
                REG_CHARGE_STOP:  cfg_next.charge_stop_tick  = wr_data;
                REG_PULSE_ON:     cfg_next.pulse_on_tick     = wr_data;
                REG_PULSE_OFF:    cfg_next.pulse_off_tick    = wr_data;
                REG_MIN_PERIOD:   cfg_next.min_period        = wr_data;
                REG_CYCLE_PERIOD: cfg_next.cycle_period      = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_start_tick <= RST_CHARGE_START;
            cfg_reg.charge_stop_tick  <= RST_CHARGE_STOP;
            cfg_reg.pulse_on_tick     <= RST_PULSE_ON;
            cfg_reg.pulse_off_tick    <= RST_PULSE_OFF;
            cfg_reg.min_period        <= RST_MIN_PERIOD;
            cfg_reg.cycle_period      <= RST_CYCLE_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/lcfps_core.sv @@
//------------------------------------------------------------------------------
// Sequencer tick engine
// Input word register, per-tick state update and result word register.
//------------------------------------------------------------------------------
`default_nettype none

`include "laser_charge_fire_pulse_sequencer_defines.svh"

module lcfps_core #(
    parameter int TICK_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lcfps_pkg::cfg_t cfg,
    lcfps_in_if.sink         in_ch,
    lcfps_out_if.source      out_ch
);
    import lcfps_pkg::*;

    localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

    // input word stage
    logic in_valid_reg;
    logic fire_cmd_reg;
    logic charge_cmd_reg;
    logic request_reg;

    // sequencer state
    logic [TICK_BITS-1:0] tick_count_reg;
    logic [TICK_BITS-1:0] tick_count_next;
    logic                 running_reg;
    logic                 running_next;
    logic                 inhibit_reg;
    logic                 inhibit_next;
    logic                 fire_reg;
    logic                 fire_next;

    // result word stage
    logic out_valid_reg;
    logic out_inhibit_reg;
    logic out_fire_reg;
    logic out_running_reg;
    logic out_taken_reg;

    logic                 advance;
    logic                 start;
    logic                 active;
    logic                 cycle_end;
    logic                 taken;
    logic [TICK_BITS-1:0] t;
    logic [TICK_BITS-1:0] start_t;
    logic [TICK_BITS-1:0] stop_t;
    logic [TICK_BITS-1:0] on_t;
    logic [TICK_BITS-1:0] off_t;
    logic [CMP_W-1:0]     t_ext;
    logic [CMP_W-1:0]     min_ext;
    logic [CMP_W-1:0]     period_ext;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;

    assign start_t    = TICK_BITS'(cfg.charge_start_tick);
    assign stop_t     = TICK_BITS'(cfg.charge_stop_tick);
    assign on_t       = TICK_BITS'(cfg.pulse_on_tick);
    assign off_t      = TICK_BITS'(cfg.pulse_off_tick);
    assign min_ext    = CMP_W'(cfg.min_period);
    assign period_ext = CMP_W'(cfg.cycle_period);

    always_comb
    begin
        start  = !running_reg && (fire_cmd_reg || request_reg);
        active = running_reg || start;
        taken  = start && request_reg;
        t      = start ? start_t : tick_count_reg;
        t_ext  = CMP_W'(t);

        inhibit_next = inhibit_reg;
        fire_next    = fire_reg;
        if (!active)
        begin
            inhibit_next = !charge_cmd_reg;
        end
        else if (t == start_t)
        begin
            inhibit_next = 1'b0;
        end
        else if (t == stop_t)
        begin
            inhibit_next = 1'b1;
        end
        else if (t == on_t)
        begin
            fire_next = 1'b1;
        end
        else if (t == off_t)
        begin
            fire_next = 1'b0;
        end

        cycle_end = ((period_ext < min_ext) && (t_ext >= min_ext)) || (t_ext >= period_ext);
        running_next    = active && !cycle_end;
        tick_count_next = active ? t + 1'b1 : tick_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            tick_count_reg <= '0;
            running_reg    <= 1'b0;
            inhibit_reg    <= 1'b1;
            fire_reg       <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                tick_count_reg <= tick_count_next;
                running_reg    <= running_next;
                inhibit_reg    <= inhibit_next;
                fire_reg       <= fire_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            fire_cmd_reg   <= in_ch.fire_command;
            charge_cmd_reg <= in_ch.charge_command;
            request_reg    <= in_ch.fire_request;
        end
        if (advance)
        begin
            out_inhibit_reg <= inhibit_next;
            out_fire_reg    <= fire_next;
            out_running_reg <= running_next;
            out_taken_reg   <= taken;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.inhibit_out   = out_inhibit_reg;
    assign out_ch.fire_out      = out_fire_reg;
    assign out_ch.cycle_running = out_running_reg;
    assign out_ch.request_taken = out_taken_reg;

    `LCFPS_ASSERT_NEXT(a_state_holds, clk, rst_n, !advance,
        $stable({tick_count_reg, running_reg, inhibit_reg, fire_reg}),
        "sequencer state changed without a tick")

    `LCFPS_ASSERT_NEXT(a_no_take_while_running, clk, rst_n, advance && running_reg,
        !out_taken_reg, "request consumed while a cycle was running")

    `LCFPS_ASSERT_NEXT(a_idle_follows_charge, clk, rst_n,
        advance && !running_reg && !fire_cmd_reg && !request_reg,
        (out_inhibit_reg == !$past(charge_cmd_reg)) && !out_running_reg,
        "idle inhibit does not follow the charge command")

    `LCFPS_ASSERT(a_result_matches_state, clk, rst_n,
        out_valid_reg |-> (out_running_reg == running_reg || in_valid_reg),
        "result word and running state disagree")

endmodule

`default_nettype wire

@@ rtl/laser_charge_fire_pulse_sequencer.sv @@
// A tick word accepted into the input word register moves through the state update into
// the result word register when the result word register is empty or being taken.
// Throughput: one tick word per cycle while the result channel is ready; the state update
// is a combinational compare and increment between the input and result word registers.
// Reset: asynchronous active low; idle, inhibit asserted, fire low, count zero,
// configuration registers at their defaults.
//------------------------------------------------------------------------------
// Laser charge/fire pulse sequencer
// Per-tick charge inhibit and fire pulse sequencing with programmable ticks.
//------------------------------------------------------------------------------
`default_nettype none

module laser_charge_fire_pulse_sequencer #(
    parameter int TICK_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire lcfps_pkg::cfg_idx_t   cfg_wr_index,
    input  wire lcfps_pkg::cfg_word_t  cfg_wr_data,
    lcfps_in_if.sink                  in_ch,
    lcfps_out_if.source               out_ch
);
    import lcfps_pkg::*;

    cfg_t cfg;

    lcfps_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    lcfps_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

@@ dv/tb_laser_charge_fire_pulse_sequencer.sv @@
//------------------------------------------------------------------------------
// Laser charge/fire pulse sequencer testbench
// Drives tick words with random command levels through several register
// settings and idle/stall mixes. Every result word is checked against a
// tick-by-tick model of the charge inhibit and fire sequencing.
//------------------------------------------------------------------------------
module tb_laser_charge_fire_pulse_sequencer;

    import lcfps_pkg::*;

    localparam int TICK_W         = 16;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 200;

    typedef struct packed {
        logic fire_command;
        logic charge_command;
        logic fire_request;
    } tick_word_t;

    typedef struct packed {
        logic inhibit_out;
        logic fire_out;
        logic cycle_running;
        logic request_taken;
    } level_word_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_wr_en;
    cfg_idx_t  cfg_wr_index;
    cfg_word_t cfg_wr_data;

    lcfps_in_if  in_ch();
    lcfps_out_if out_ch();

    laser_charge_fire_pulse_sequencer #(
        .TICK_BITS(TICK_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );

    // sequencer model state
    cfg_t              seq_cfg;
    logic [TICK_W-1:0] seq_count;
    logic              seq_running;
    logic              seq_inhibit;
    logic              seq_fire;

    tick_word_t  tick_q[$];
    level_word_t level_exp_q[$];
    tick_word_t  drive_word;
    level_word_t seen_word;
    level_word_t want_word;
    string       level_name[4] = '{"request_taken", "cycle_running", "fire_out", "inhibit_out"};

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_served;
    int hold_left;
    int quiet_cycles;
    int words_sent = 0;
    int words_checked = 0;
    int mismatches = 0;
    int settings_loaded = 0;

    always #6 clk = ~clk;

    function automatic level_word_t next_levels(tick_word_t w);
        level_word_t       r;
        logic              taken;
        logic              active;
        logic [TICK_W-1:0] t;
        taken  = 1'b0;
        active = 1'b1;
        if (!seq_running)
        begin
            if (w.fire_command || w.fire_request)
            begin
                taken       = w.fire_request;
                seq_count   = seq_cfg.charge_start_tick;
                seq_running = 1'b1;
            end
            else
            begin
                seq_inhibit = !w.charge_command;
                active      = 1'b0;
            end
        end
        if (active)
        begin
            t = seq_count;
            // one event per tick: release, reassert, fire on, fire off
            if (t == seq_cfg.charge_start_tick)
                seq_inhibit = 1'b0;
            else if (t == seq_cfg.charge_stop_tick)
                seq_inhibit = 1'b1;
            else if (t == seq_cfg.pulse_on_tick)
                seq_fire = 1'b1;
            else if (t == seq_cfg.pulse_off_tick)
                seq_fire = 1'b0;
            if ((seq_cfg.cycle_period < seq_cfg.min_period && t >= seq_cfg.min_period) ||
                t >= seq_cfg.cycle_period)
                seq_running = 1'b0;
            seq_count = t + 1'b1;
        end
        r.inhibit_out   = seq_inhibit;
        r.fire_out      = seq_fire;
        r.cycle_running = seq_running;
        r.request_taken = taken;
        return r;
    endfunction

    function automatic cfg_word_t reg_value(cfg_t c, cfg_idx_t idx);
        case (cfg_index_e'(idx))
            REG_CHARGE_START: return c.charge_start_tick;
            REG_CHARGE_STOP:  return c.charge_stop_tick;
            REG_PULSE_ON:     return c.pulse_on_tick;
            REG_PULSE_OFF:    return c.pulse_off_tick;
            REG_MIN_PERIOD:   return c.min_period;
            REG_CYCLE_PERIOD: return c.cycle_period;
            default:          return cfg_word_t'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t      c;
        cfg_word_t base;
        base                = ($urandom_range(0, 3) == 0) ? 16'd65480 : 16'd0;
        c.charge_start_tick = base + cfg_word_t'($urandom_range(0, 15));
        c.charge_stop_tick  = base + cfg_word_t'($urandom_range(0, 55));
        c.pulse_on_tick     = base + cfg_word_t'($urandom_range(0, 55));
        c.pulse_off_tick    = base + cfg_word_t'($urandom_range(0, 55));
        c.min_period        = base + cfg_word_t'($urandom_range(0, 55));
        c.cycle_period      = base + cfg_word_t'($urandom_range(0, 55));
        return c;
    endfunction

    // spare indexes get random data and must be ignored
    task automatic load_settings(cfg_t c);
        for (int i = 0; i < 2**CFG_IDX_W; i++)
        begin
            @(posedge clk);
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= cfg_idx_t'(i);
            cfg_wr_data  <= reg_value(c, cfg_idx_t'(i));
        end
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        seq_cfg = c;
        settings_loaded++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_q.size() != 0 || in_ch.valid || level_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // driver: predicts each accepted tick word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.fire_command   <= 1'b0;
            in_ch.charge_command <= 1'b0;
            in_ch.fire_request   <= 1'b0;
            seq_count   = '0;
            seq_running = 1'b0;
            seq_inhibit = 1'b1;
            seq_fire    = 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                level_exp_q.push_back(next_levels({in_ch.fire_command, in_ch.charge_command,
                                                   in_ch.fire_request}));
                words_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (tick_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    drive_word = tick_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.fire_command   <= drive_word.fire_command;
                    in_ch.charge_command <= drive_word.charge_command;
                    in_ch.fire_request   <= drive_word.fire_request;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks result words, drives ready and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_served  <= 0;
            hold_left    <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                seen_word = {out_ch.inhibit_out, out_ch.fire_out, out_ch.cycle_running,
                             out_ch.request_taken};
                if (level_exp_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word %b with nothing expected", $time, seen_word);
                end
                else
                begin
                    want_word = level_exp_q.pop_front();
                    for (int b = 0; b < 4; b++)
                        if (seen_word[b] !== want_word[b])
                        begin
                            mismatches++;
                            $display("%0t: %s expected %b actual %b", $time, level_name[b],
                                     want_word[b], seen_word[b]);
                        end
                    words_checked++;
                end
            end
            if (hold_served != hold_asked)
            begin
                hold_served  <= hold_asked;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [2:0] reset_cfg_ticks[];
        logic [2:0] short_cfg_ticks[];
        cfg_t plan;
        int   fire_pct;
        int   req_pct;
        tick_word_t w;

        reset_cfg_ticks = '{3'b000, 3'b010, 3'b000, 3'b011,
                            3'b111, 3'b100, 3'b010, 3'b000};
        short_cfg_ticks = '{3'b100, 3'b000, 3'b000, 3'b001, 3'b000,
                            3'b000, 3'b101, 3'b000, 3'b000, 3'b010,
                            3'b110, 3'b000, 3'b000};
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_index         = REG_CHARGE_START;
        cfg_wr_data          = '0;
        seq_cfg = '{charge_start_tick: RST_CHARGE_START, charge_stop_tick: RST_CHARGE_STOP,
                    pulse_on_tick: RST_PULSE_ON, pulse_off_tick: RST_PULSE_OFF,
                    min_period: RST_MIN_PERIOD, cycle_period: RST_CYCLE_PERIOD};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: idle charge control, request and command starts
        foreach (reset_cfg_ticks[i])
            tick_q.push_back(reset_cfg_ticks[i]);
        wait_drained();

        // equal release/reassert and fire on/off ticks, period below minimum
        load_settings('{charge_start_tick: 16'd2, charge_stop_tick: 16'd2,
                        pulse_on_tick: 16'd3, pulse_off_tick: 16'd3,
                        min_period: 16'd6, cycle_period: 16'd4});
        foreach (short_cfg_ticks[i])
            tick_q.push_back(short_cfg_ticks[i]);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: plan = '{default: 16'h0000};
                1: plan = '{default: 16'hFFFF};
                2: plan = '{charge_start_tick: 16'd1, charge_stop_tick: 16'd6,
                            pulse_on_tick: 16'd8, pulse_off_tick: 16'd9,
                            min_period: 16'd30, cycle_period: 16'd12};
                3: plan = '{charge_start_tick: 16'd65500, charge_stop_tick: 16'd65510,
                            pulse_on_tick: 16'd65520, pulse_off_tick: 16'd65530,
                            min_period: 16'd0, cycle_period: 16'hFFFF};
                default: plan = random_settings();
            endcase
            load_settings(plan);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            fire_pct = $urandom_range(3, 40);
            req_pct  = $urandom_range(3, 30);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                w.fire_command   = ($urandom_range(0, 99) < fire_pct);
                w.charge_command = $urandom_range(0, 1);
                w.fire_request   = ($urandom_range(0, 99) < req_pct);
                tick_q.push_back(w);
            end
            // long receiver hold-off while the sender keeps offering
            if (p == 4)
                hold_asked++;
            wait_drained();
        end

        $display("Sent %0d tick words across %0d register settings with idle, stall and",
                 words_sent, settings_loaded);
        $display("hold-off mixes; %0d result words checked, %0d mismatches.",
                 words_checked, mismatches);
        if (mismatches == 0 && level_exp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lcfps_pkg.sv
rtl/lcfps_in_if.sv
rtl/lcfps_out_if.sv
rtl/lcfps_cfg_regs.sv
rtl/lcfps_core.sv
rtl/laser_charge_fire_pulse_sequencer.sv
dv/tb_laser_charge_fire_pulse_sequencer.sv
